FILE: hdl/qtc_pkg.sv
// Package for the quintic trajectory coefficient block.
// Holds the request and result types, the status codes and the default widths.
// Depends on nothing.
package qtc_pkg;

  localparam int unsigned QTC_FRAC_BITS = 16;
  localparam int unsigned QTC_COEF_W    = 32;
  localparam int unsigned QTC_DUR_W     = 31;

  typedef enum logic [1:0] {
    QTC_STATUS_OK   = 2'd0,
    QTC_STATUS_ZERO = 2'd1,
    QTC_STATUS_SAT  = 2'd2
  } qtc_status_e;

  typedef struct packed {
    logic signed [QTC_COEF_W-1:0] start_position;
    logic signed [QTC_COEF_W-1:0] start_velocity;
    logic signed [QTC_COEF_W-1:0] start_acceleration;
    logic signed [QTC_COEF_W-1:0] end_position;
    logic signed [QTC_COEF_W-1:0] end_velocity;
    logic signed [QTC_COEF_W-1:0] end_acceleration;
    logic        [QTC_DUR_W-1:0]  duration;
  } qtc_req_t;

  typedef struct packed {
    logic signed [QTC_COEF_W-1:0] coef_0;
    logic signed [QTC_COEF_W-1:0] coef_1;
    logic signed [QTC_COEF_W-1:0] coef_2;
    logic signed [QTC_COEF_W-1:0] coef_3;
    logic signed [QTC_COEF_W-1:0] coef_4;
    logic signed [QTC_COEF_W-1:0] coef_5;
    qtc_status_e                  status;
  } qtc_res_t;

endpackage

FILE: hdl/quintic_trajectory_coefficients_top.sv
// Quintic trajectory coefficients: a new request may be accepted in every cycle.
// The done strobe follows the accepting edge through the power chain D^2..D^5
// (four two-stage multipliers) and the 32-step divider.
// Throughput: one request per cycle; busy_o stays low and the receiver cannot stall.
// Reset clears only the valid bits, so no result appears until a request is taken.
module quintic_trajectory_coefficients_top import qtc_pkg::*; #(
  parameter int unsigned FRAC_BITS = QTC_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  qtc_req_t req_i,
  output logic     done_o,
  output qtc_res_t res_o
);

  // Signed width that holds any of the three numerators before the division.
  localparam int unsigned NS   = 100 + 5 * FRAC_BITS;
  localparam int unsigned DK_W = 5 * QTC_DUR_W;

  typedef struct packed {
    logic signed [QTC_COEF_W-1:0] c0;
    logic signed [QTC_COEF_W-1:0] c1;
    logic signed [QTC_COEF_W-1:0] c2;
    logic                         zero;
  } low_t;

  // The pipeline never stalls, so a request is taken whenever start is high.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 0: register the duration and the small integer combinations.
  // Index 0, 1, 2 of the arrays stands for the cubic, quartic and quintic terms.
  // ---------------------------------------------------------------------------
  logic signed [32:0] h_d, a0_33;
  logic        [32:0] mag, half;
  logic signed [36:0] v0e, v1e;
  logic signed [34:0] a0e, a1e;
  logic signed [37:0] c0_d [3];
  logic signed [36:0] c1_d [3];
  logic signed [34:0] c2_d [3];
  logic signed [37:0] c0_q [3];
  logic signed [36:0] c1_q [3];
  logic signed [34:0] c2_q [3];
  logic [QTC_DUR_W-1:0] dur_q;
  low_t low_d, low_q;
  logic v_q [9];

  always_comb begin
    h_d   = 33'(req_i.end_position) - 33'(req_i.start_position);
    v0e   = 37'(req_i.start_velocity);
    v1e   = 37'(req_i.end_velocity);
    a0e   = 35'(req_i.start_acceleration);
    a1e   = 35'(req_i.end_acceleration);
    c0_d[0] = 38'(h_d) * 38'sd20;
    c0_d[1] = 38'(h_d) * (-38'sd30);
    c0_d[2] = 38'(h_d) * 38'sd12;
    c1_d[0] = -(v1e * 37'sd8 + v0e * 37'sd12);
    c1_d[1] = v1e * 37'sd14 + v0e * 37'sd16;
    c1_d[2] = -((v1e + v0e) * 37'sd6);
    c2_d[0] = a1e - a0e * 35'sd3;
    c2_d[1] = a0e * 35'sd3 - a1e * 35'sd2;
    c2_d[2] = a1e - a0e;
    // Half the start acceleration, rounded half away from zero on the magnitude.
    a0_33 = 33'(req_i.start_acceleration);
    mag   = a0_33[32] ? 33'(-a0_33) : 33'(a0_33);
    half  = (mag + 33'd1) >> 1;
    low_d.c0   = req_i.start_position;
    low_d.c1   = req_i.start_velocity;
    low_d.c2   = $signed(a0_33[32] ? QTC_COEF_W'(-half) : QTC_COEF_W'(half));
    low_d.zero = (req_i.duration == '0);
  end

  always_ff @(posedge clk_i) begin
    c0_q  <= c0_d;
    c1_q  <= c1_d;
    c2_q  <= c2_d;
    dur_q <= req_i.duration;
    low_q <= low_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= start_i && !busy_o;
      for (int i = 1; i < 9; i++) v_q[i] <= v_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier chain. Multipliers register partial products, then the product; the
  // duration and the constant terms follow through delay lines so all operands meet.
  // ---------------------------------------------------------------------------
  logic [QTC_DUR_W-1:0] dur_t2, dur_t4, dur_t6;
  logic signed [62:0]  d2_t2;
  logic signed [93:0]  d3_t4, d3_t8;
  logic signed [124:0] d4_t6, d4_t8;
  logic signed [155:0] d5_t8;

  qtc_delay #(.W(QTC_DUR_W), .DEPTH(2)) u_dur2 (.clk_i, .d_i(dur_q),  .q_o(dur_t2));
  qtc_delay #(.W(QTC_DUR_W), .DEPTH(2)) u_dur4 (.clk_i, .d_i(dur_t2), .q_o(dur_t4));
  qtc_delay #(.W(QTC_DUR_W), .DEPTH(2)) u_dur6 (.clk_i, .d_i(dur_t4), .q_o(dur_t6));

  qtc_wmul #(.A_W(32), .B_W(QTC_DUR_W)) u_d2 (
    .clk_i, .a_i($signed({1'b0, dur_q})), .b_i(dur_q), .p_o(d2_t2));
  qtc_wmul #(.A_W(63), .B_W(QTC_DUR_W)) u_d3 (
    .clk_i, .a_i(d2_t2), .b_i(dur_t2), .p_o(d3_t4));
  qtc_wmul #(.A_W(94), .B_W(QTC_DUR_W)) u_d4 (
    .clk_i, .a_i(d3_t4), .b_i(dur_t4), .p_o(d4_t6));
  qtc_wmul #(.A_W(125), .B_W(QTC_DUR_W)) u_d5 (
    .clk_i, .a_i(d4_t6), .b_i(dur_t6), .p_o(d5_t8));

  qtc_delay #(.W(94),  .DEPTH(4)) u_d3dl (.clk_i, .d_i(d3_t4), .q_o(d3_t8));
  qtc_delay #(.W(125), .DEPTH(2)) u_d4dl (.clk_i, .d_i(d4_t6), .q_o(d4_t8));

  logic [DK_W-1:0]       dk      [3];
  logic [NS-1:0]         abs_t8  [3];
  logic                  neg_t8  [3];
  logic signed [QTC_COEF_W-1:0] coef_t42 [3];
  logic                  sat_t42 [3];
  logic                  vld_t42 [3];

  assign dk[0] = DK_W'($unsigned(d3_t8));
  assign dk[1] = DK_W'($unsigned(d4_t8));
  assign dk[2] = d5_t8[DK_W-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_coef
    localparam int unsigned P = k + 3;
    logic signed [37:0] c0_t4;
    logic signed [67:0] c1d_t2, c1d_t4;
    logic signed [65:0] c2d_t2;
    logic signed [96:0] c2d2_t4;
    logic signed [NS-1:0] num_q;
    logic [NS-1:0] abs_q;
    logic          neg_q;

    qtc_wmul #(.A_W(37), .B_W(QTC_DUR_W)) u_c1 (
      .clk_i, .a_i(c1_q[k]), .b_i(dur_q), .p_o(c1d_t2));
    qtc_wmul #(.A_W(35), .B_W(QTC_DUR_W)) u_c2a (
      .clk_i, .a_i(c2_q[k]), .b_i(dur_q), .p_o(c2d_t2));
    qtc_wmul #(.A_W(66), .B_W(QTC_DUR_W)) u_c2b (
      .clk_i, .a_i(c2d_t2), .b_i(dur_t2), .p_o(c2d2_t4));

    qtc_delay #(.W(38), .DEPTH(4)) u_c0dl (.clk_i, .d_i(c0_q[k]), .q_o(c0_t4));
    qtc_delay #(.W(68), .DEPTH(2)) u_c1dl (.clk_i, .d_i(c1d_t2), .q_o(c1d_t4));

    // Numerator scaled by S^P, with S = 2^FRAC_BITS and P = k + 3, then split into sign and
    // magnitude for the unsigned divider.
    always_ff @(posedge clk_i) begin
      num_q <= (NS'(c0_t4)   <<< (P * FRAC_BITS))
             + (NS'(c1d_t4)  <<< ((P - 1) * FRAC_BITS))
             + (NS'(c2d2_t4) <<< ((P - 2) * FRAC_BITS));
      neg_q <= num_q[NS-1];
      abs_q <= num_q[NS-1] ? NS'(-num_q) : NS'(num_q);
    end

    qtc_delay #(.W(NS), .DEPTH(2)) u_absdl (.clk_i, .d_i(abs_q), .q_o(abs_t8[k]));
    qtc_delay #(.W(1),  .DEPTH(2)) u_negdl (.clk_i, .d_i(neg_q), .q_o(neg_t8[k]));

    qtc_div #(.N_W(NS), .DK_W(DK_W)) u_div (
      .clk_i,
      .rst_ni,
      .valid_i (v_q[8]),
      .num_i   (abs_t8[k]),
      .dk_i    (dk[k]),
      .neg_i   (neg_t8[k]),
      .valid_o (vld_t42[k]),
      .coef_o  (coef_t42[k]),
      .sat_o   (sat_t42[k])
    );
  end

  // The three low coefficients wait for the divider results.
  low_t low_t42;
  qtc_delay #(.W($bits(low_t)), .DEPTH(42)) u_lowdl (.clk_i, .d_i(low_q), .q_o(low_t42));

  // ---------------------------------------------------------------------------
  // Output register. A zero duration overrides saturation and clears the
  // divided coefficients.
  // ---------------------------------------------------------------------------
  qtc_res_t res_d;
  logic     done_q;

  always_comb begin
    res_d.coef_0 = low_t42.c0;
    res_d.coef_1 = low_t42.c1;
    res_d.coef_2 = low_t42.c2;
    if (low_t42.zero) begin
      res_d.coef_3 = '0;
      res_d.coef_4 = '0;
      res_d.coef_5 = '0;
      res_d.status = QTC_STATUS_ZERO;
    end else begin
      res_d.coef_3 = coef_t42[0];
      res_d.coef_4 = coef_t42[1];
      res_d.coef_5 = coef_t42[2];
      res_d.status = (sat_t42[0] || sat_t42[1] || sat_t42[2]) ? QTC_STATUS_SAT
                                                               : QTC_STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_t42[0] && vld_t42[1] && vld_t42[2];
    end
  end

  assign done_o = done_q;

endmodule

FILE: hdl/qtc_delay.sv
// Fixed-length delay line that keeps side data aligned with the pipeline.
// Depends on nothing.
module qtc_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: hdl/qtc_wmul.sv
// Two-stage signed by unsigned multiplier built from 32-bit partial products.
// Depends on nothing.
module qtc_wmul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 31
) (
  input  logic                       clk_i,
  input  logic signed [A_W-1:0]      a_i,
  input  logic        [B_W-1:0]      b_i,
  output logic signed [A_W+B_W-1:0]  p_o
);

  localparam int unsigned NC   = (A_W + 31) / 32;
  localparam int unsigned PP_W = 34 + B_W;
  localparam int unsigned SW   = NC * 32 + B_W + 2;

  logic signed [NC*32-1:0] a_ext;
  logic signed [PP_W-1:0]  pp_d [NC];
  logic signed [PP_W-1:0]  pp_q [NC];
  logic signed [SW-1:0]    sum;

  assign a_ext = (NC*32)'(a_i);

  // The top chunk carries the sign, the lower chunks are unsigned.
  always_comb begin
    logic signed [32:0] chunk;
    for (int j = 0; j < NC; j++) begin
      chunk    = $signed({(j == NC - 1) ? a_ext[32*j+31] : 1'b0, a_ext[32*j +: 32]});
      pp_d[j]  = PP_W'(chunk) * PP_W'($signed({1'b0, b_i}));
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
    p_o  <= sum[A_W+B_W-1:0];
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < NC; j++) begin
      sum = sum + (SW'(pp_q[j]) <<< (32 * j));
    end
  end

endmodule

FILE: hdl/qtc_div.sv
// Pipelined restoring divider with rounding to nearest and 32-bit saturation.
// Depends on qtc_pkg for the coefficient width.
module qtc_div import qtc_pkg::*; #(
  parameter int unsigned N_W  = 180,
  parameter int unsigned DK_W = 155
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic        [N_W-1:0]        num_i,
  input  logic        [DK_W-1:0]       dk_i,
  input  logic                         neg_i,
  output logic                         valid_o,
  output logic signed [QTC_COEF_W-1:0] coef_o,
  output logic                         sat_o
);

  localparam int unsigned Q_W = QTC_COEF_W;
  localparam int unsigned CW  = (N_W + 2 > DK_W + Q_W + 2) ? N_W + 2 : DK_W + Q_W + 2;

  logic [CW-1:0]  num_p, den_p;
  logic           sat_p;
  logic [CW-1:0]  rem_q [Q_W+1];
  logic [CW-1:0]  den_q [Q_W+1];
  logic [Q_W-1:0] quo_q [Q_W+1];
  logic           neg_q [Q_W+1];
  logic           sat_q [Q_W+1];
  logic           vld_q [Q_W+1];

  logic [Q_W-1:0] lim, qsat;
  logic           sat_f;
  logic           out_neg_q;

  // Adding D^k before dividing by 2 D^k rounds the magnitude half away from zero.
  assign num_p = CW'(num_i) + CW'(dk_i);
  assign den_p = CW'(dk_i) << 1;
  assign sat_p = num_p >= (den_p << Q_W);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_p;
    den_q[0] <= den_p;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
    sat_q[0] <= sat_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Q_W; i++) vld_q[i] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= Q_W; i++) vld_q[i] <= vld_q[i-1];
      valid_o <= vld_q[Q_W];
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int unsigned B = Q_W - 1 - j;
    logic [CW-1:0] sh;
    logic          take;
    assign sh   = den_q[j] << B;
    assign take = rem_q[j] >= sh;
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= take ? rem_q[j] - sh : rem_q[j];
      quo_q[j+1] <= quo_q[j] | (Q_W'(take) << B);
      den_q[j+1] <= den_q[j];
      neg_q[j+1] <= neg_q[j];
      sat_q[j+1] <= sat_q[j];
    end
  end

  assign lim   = neg_q[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
  assign sat_f = sat_q[Q_W] || (quo_q[Q_W] > lim);
  assign qsat  = sat_f ? lim : quo_q[Q_W];

  always_ff @(posedge clk_i) begin
    coef_o    <= $signed(neg_q[Q_W] ? Q_W'(-qsat) : qsat);
    sat_o     <= sat_f;
    out_neg_q <= neg_q[Q_W];
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(Q_W+2) valid_o)
    else $error("divider lost or delayed a request");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Q_W] && !sat_q[Q_W]) |-> (rem_q[Q_W] < den_q[Q_W]))
    else $error("division remainder not below divisor");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !sat_o) |-> ((coef_o == '0) || (coef_o[Q_W-1] == out_neg_q)))
    else $error("coefficient sign does not match numerator sign");

endmodule
